FILE: rtl/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants for the meter frame parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

	localparam int ADDRESS_BYTES_DEF = 7;
	localparam int PAYLOAD_DEPTH_DEF = 256;

	localparam logic [7:0] START_BYTE = 8'h68;
	localparam logic [7:0] END_BYTE   = 8'h16;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_DONE     = 2'd1,
		ST_SUM_ERR  = 2'd2,
		ST_END_ERR  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0]  meter_type;
		logic [55:0] meter_address;
		logic [7:0]  control_code;
		logic [7:0]  payload_length;
	} header_t;

	typedef struct packed {
		logic       en;
		logic [7:0] index;
		logic [7:0] data;
	} wr_req_t;

endpackage

FILE: rtl/mfp_payload_ram.sv
// ----------------------------------------------------------------------------
// mfp_payload_ram
// Payload byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfp_payload_ram #(
	parameter int PAYLOAD_DEPTH = mfp_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic            clk,
	input  mfp_pkg::wr_req_t wr,
	input  logic            rd_en,
	input  logic [7:0]      rd_index,
	output logic [7:0]      rd_data
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic [7:0] mem [PAYLOAD_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.index[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_index[AW-1:0]];
		end
	end

endmodule

FILE: rtl/mfp_parser.sv
// ----------------------------------------------------------------------------
// mfp_parser
// Frame state machine: header registers, running checksum, byte counter and
// payload write requests. Presents the header as it stands after this byte.
// ----------------------------------------------------------------------------
module mfp_parser #(
	parameter int ADDRESS_BYTES = mfp_pkg::ADDRESS_BYTES_DEF,
	parameter int PAYLOAD_DEPTH = mfp_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	output mfp_pkg::status_t  status,
	output mfp_pkg::header_t  hdr_next,
	output mfp_pkg::wr_req_t  wr
);

	typedef enum logic [2:0] {
		PH_HUNT, PH_TYPE, PH_ADDR, PH_CTRL, PH_LEN, PH_DATA, PH_SUM, PH_END
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [7:0]       cnt_q, cnt_d;
	logic [7:0]       sum_q, sum_d;
	mfp_pkg::header_t hdr_q;
	logic [7:0]       cnt_inc;

	assign cnt_inc = cnt_q + 8'd1;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		sum_d    = sum_q;
		hdr_next = hdr_q;
		status   = mfp_pkg::ST_BUSY;
		wr.en    = 1'b0;
		wr.index = cnt_q;
		wr.data  = rx_byte;
		if (step) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == mfp_pkg::START_BYTE) begin
						sum_d   = mfp_pkg::START_BYTE;
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					hdr_next.meter_type    = rx_byte;
					hdr_next.meter_address = '0;
					sum_d   = sum_q + rx_byte;
					cnt_d   = '0;
					phase_d = PH_ADDR;
				end
				PH_ADDR: begin
					hdr_next.meter_address = hdr_q.meter_address
						| (56'(rx_byte) << {cnt_q[2:0], 3'b000});
					sum_d = sum_q + rx_byte;
					cnt_d = cnt_inc;
					if (cnt_inc >= 8'(ADDRESS_BYTES)) begin
						cnt_d   = '0;
						phase_d = PH_CTRL;
					end
				end
				PH_CTRL: begin
					hdr_next.control_code = rx_byte;
					sum_d   = sum_q + rx_byte;
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					hdr_next.payload_length = rx_byte;
					sum_d   = sum_q + rx_byte;
					cnt_d   = '0;
					phase_d = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
				end
				PH_DATA: begin
					wr.en = ({1'b0, cnt_q} < 9'(PAYLOAD_DEPTH));
					sum_d = sum_q + rx_byte;
					cnt_d = cnt_inc;
					if (cnt_inc >= hdr_q.payload_length) begin
						cnt_d   = '0;
						phase_d = PH_SUM;
					end
				end
				PH_SUM: begin
					if (sum_q == rx_byte) begin
						phase_d = PH_END;
					end else begin
						phase_d = PH_HUNT;
						status  = mfp_pkg::ST_SUM_ERR;
					end
				end
				PH_END: begin
					phase_d = PH_HUNT;
					status  = (rx_byte == mfp_pkg::END_BYTE) ? mfp_pkg::ST_DONE
						: mfp_pkg::ST_END_ERR;
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			sum_q   <= mfp_pkg::START_BYTE;
			hdr_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			hdr_q   <= hdr_next;
		end
	end

endmodule

FILE: rtl/meter_frame_parser.sv
// ----------------------------------------------------------------------------
// meter_frame_parser
// Parses received bytes into meter frames and answers payload read requests.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (lowest bit up)
// s_*      in   tdata: rx_byte[7:0], read_index[15:8]; tuser: kind
// m_*      out  tdata: status[1:0], meter_type[9:2], meter_address[65:10],
//               control_code[73:66], payload_length[81:74], read_data[89:82]
//
// One request per cycle sustained while the output is not stalled; each result
// is registered first in stage 1 (parser update and payload RAM read), then in
// the output register. Reset clears the parser and both stage valids; the
// payload RAM is not cleared. A stalled output holds both stages and drops
// s_tready only when both are full.
// ----------------------------------------------------------------------------
module meter_frame_parser #(
	parameter int ADDRESS_BYTES = mfp_pkg::ADDRESS_BYTES_DEF,
	parameter int PAYLOAD_DEPTH = mfp_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte, read_index
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // status, meter_type, meter_address,
	                               // control_code, payload_length, read_data
);

	logic             accept, step, rd_req, advance;
	mfp_pkg::status_t status;
	mfp_pkg::header_t hdr_next;
	mfp_pkg::wr_req_t wr;
	logic [7:0]       ram_rdata;

	logic             valid_s1;
	mfp_pkg::status_t status_s1;
	mfp_pkg::header_t hdr_s1;
	logic             rd_ok_s1;
	logic [7:0]       rdata_out;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign step     = accept && !s_tuser;
	assign rd_req   = accept && s_tuser;

	mfp_parser #(
		.ADDRESS_BYTES(ADDRESS_BYTES),
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rx_byte  (s_tdata[7:0]),
		.status   (status),
		.hdr_next (hdr_next),
		.wr       (wr)
	);

	mfp_payload_ram #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_ram (
		.clk      (clk),
		.wr       (wr),
		.rd_en    (rd_req),
		.rd_index (s_tdata[15:8]),
		.rd_data  (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			hdr_s1    <= hdr_next;
			rd_ok_s1  <= s_tuser && ({1'b0, s_tdata[15:8]} < 9'(PAYLOAD_DEPTH));
		end
	end

	// read data only for in-range read requests, zero otherwise
	assign rdata_out = rd_ok_s1 ? ram_rdata : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata <= {6'd0, rdata_out, hdr_s1.payload_length, hdr_s1.control_code,
				hdr_s1.meter_address, hdr_s1.meter_type, status_s1};
		end
	end

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("s_tready low while a stage is free");

	a_read_reply_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[89:82] != 8'd0) |-> (m_tdata[1:0] == mfp_pkg::ST_BUSY))
		else $error("read reply carries a frame status");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && !accept) |=> (m_tvalid && !valid_s1))
		else $error("stage 1 result lost");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> step)
		else $error("payload write without a parse request");

endmodule
